// File: rtl/compare_expression_filter_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the compare expression filter unit
// Each macro expects signals named clk and rst_n in the calling scope.
// ----------------------------------------------------------------------------
`ifndef COMPARE_EXPRESSION_FILTER_UNIT_MACROS_SVH
`define COMPARE_EXPRESSION_FILTER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CEF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CEF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/cef_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cef_pkg
// Types, character codes and comparison codes shared by the filter unit.
// ----------------------------------------------------------------------------
package cef_pkg;

    // Verdict codes.
    localparam logic [1:0] VERDICT_PASS   = 2'd0;
    localparam logic [1:0] VERDICT_FAIL   = 2'd1;
    localparam logic [1:0] VERDICT_SYNTAX = 2'd2;

    // Comparison kinds.
    localparam logic [2:0] K_NONE = 3'd0;
    localparam logic [2:0] K_GE   = 3'd1;
    localparam logic [2:0] K_LE   = 3'd2;
    localparam logic [2:0] K_GT   = 3'd3;
    localparam logic [2:0] K_LT   = 3'd4;
    localparam logic [2:0] K_NE   = 3'd5;
    localparam logic [2:0] K_EQ   = 3'd6;
    localparam logic [2:0] K_ERR  = 3'd7;

    // Character codes.
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_0       = 8'h30;
    localparam logic [7:0] CH_9       = 8'h39;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_EQ      = 8'h3D;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_LOWER_X = 8'h78;

    typedef struct packed {
        logic [7:0]  symbol;
        logic [63:0] value;
        logic        last;
    } item_t;

    typedef struct packed {
        logic [1:0] verdict;
    } result_t;

    // One finished segment, ready for comparison.
    typedef struct packed {
        logic [2:0]  kind;
        logic        bad;
        logic [63:0] number;
    } seg_t;

    // A segment close, raised by a comma or by the final character.
    typedef struct packed {
        logic        comma;
        logic        last;
        logic        sep_or_len;
        seg_t        seg;
        logic [63:0] value;
    } event_t;

endpackage

// File: rtl/cef_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream interfaces
// Valid/ready channels for expression characters and for verdicts.
// ----------------------------------------------------------------------------
interface cef_expr_if
    import cef_pkg::*;
;
    logic  valid;
    logic  ready;
    item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface cef_result_if
    import cef_pkg::*;
;
    logic    valid;
    logic    ready;
    result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/cef_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cef_parser
// Segment parser: comparator decode and number accumulation, one character
// per advance, with the close event for the character presented.
// ----------------------------------------------------------------------------
module cef_parser
    import cef_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  item_t  item,
    input  logic   advance,
    output event_t close_event
);

    localparam logic [2:0] PH_PREFIX  = 3'd0;
    localparam logic [2:0] PH_ZERO    = 3'd1;
    localparam logic [2:0] PH_DEC     = 3'd2;
    localparam logic [2:0] PH_HEXWAIT = 3'd3;
    localparam logic [2:0] PH_HEX     = 3'd4;
    localparam logic [2:0] PH_DONE    = 3'd5;
    localparam logic [2:0] PH_BAD     = 3'd6;

    function automatic logic [4:0] hex_of(input logic [7:0] ch);
        logic [4:0] res;
        res = 5'd0;
        if (ch >= CH_0 && ch <= CH_9)
            res = {1'b1, 4'(ch - CH_0)};
        else if (ch >= CH_LOWER_A && ch <= CH_LOWER_F)
            res = {1'b1, 4'(ch - CH_LOWER_A + 8'd10)};
        else if (ch >= CH_UPPER_A && ch <= CH_UPPER_F)
            res = {1'b1, 4'(ch - CH_UPPER_A + 8'd10)};
        return res;
    endfunction

    function automatic logic [2:0] kind_from_two(input logic [7:0] a, input logic [7:0] b);
        logic [2:0] k;
        if (a == CH_GT && b == CH_EQ)        k = K_GE;
        else if (a == CH_LT && b == CH_EQ)   k = K_LE;
        else if (a == CH_GT)                 k = K_GT;
        else if (a == CH_LT)                 k = K_LT;
        else if (a == CH_BANG && b == CH_EQ) k = K_NE;
        else if (a == CH_EQ && b == CH_EQ)   k = K_EQ;
        else if (a >= CH_0 && a <= CH_9)     k = K_EQ;
        else                                 k = K_ERR;
        return k;
    endfunction

    function automatic logic [2:0] kind_from_one(input logic [7:0] a);
        logic [2:0] k;
        if (a == CH_GT)                  k = K_GT;
        else if (a == CH_LT)             k = K_LT;
        else if (a >= CH_0 && a <= CH_9) k = K_EQ;
        else                             k = K_ERR;
        return k;
    endfunction

    logic [2:0]  phase_reg, phase_next, phase_w;
    logic [1:0]  seglen_reg, seglen_next, seglen_w;
    logic [7:0]  lead_reg, lead_next, lead_w;
    logic [2:0]  kind_reg, kind_next, kind_w;
    logic [63:0] acc_reg, acc_next, acc_w;
    logic        ovf_reg, ovf_next, ovf_w;
    logic        sep_reg, sep_next;

    logic [7:0]  c;
    logic        is_space;
    logic        is_comma;
    logic        is_dec;
    logic [3:0]  dig;
    logic [4:0]  hex;
    logic [67:0] dec_sum;
    logic [2:0]  kind_eff;
    logic        kind_ok;
    logic        phase_bad;

    assign c        = item.symbol;
    assign is_space = (c >= CH_TAB && c <= CH_CR) || c == CH_SPACE;
    assign is_comma = c == CH_COMMA;
    assign is_dec   = c >= CH_0 && c <= CH_9;
    assign dig      = 4'(c - CH_0);
    assign hex      = hex_of(c);
    // Times ten as two shifted copies, plus the new digit; the top four bits flag overflow.
    assign dec_sum  = ({4'd0, acc_reg} << 3) + ({4'd0, acc_reg} << 1) + {64'd0, dig};

    // Segment state after this character, if it is neither a comma nor whitespace.
    always_comb
    begin
        phase_w  = phase_reg;
        seglen_w = seglen_reg;
        lead_w   = lead_reg;
        kind_w   = kind_reg;
        acc_w    = acc_reg;
        ovf_w    = ovf_reg;
        if (!is_space && !is_comma)
        begin
            if (seglen_reg == 2'd0)
                lead_w = c;
            else if (seglen_reg == 2'd1)
                kind_w = kind_from_two(lead_reg, c);
            if (seglen_reg != 2'd2)
                seglen_w = seglen_reg + 2'd1;
            unique case (phase_reg) inside
                PH_PREFIX:
                begin
                    if (is_dec)
                    begin
                        acc_w   = {60'd0, dig};
                        phase_w = (c == CH_0) ? PH_ZERO : PH_DEC;
                    end
                end
                PH_ZERO, PH_DEC:
                begin
                    if (phase_reg == PH_ZERO && c == CH_LOWER_X)
                        phase_w = PH_HEXWAIT;
                    else if (is_dec)
                    begin
                        phase_w = PH_DEC;
                        if (dec_sum[67:64] != 4'd0)
                            ovf_w = 1'b1;
                        else
                            acc_w = dec_sum[63:0];
                    end
                    else
                        phase_w = PH_DONE;
                end
                PH_HEXWAIT:
                begin
                    if (hex[4])
                    begin
                        acc_w   = {60'd0, hex[3:0]};
                        phase_w = PH_HEX;
                    end
                    else
                        phase_w = PH_BAD;
                end
                PH_HEX:
                begin
                    if (hex[4])
                    begin
                        if (acc_reg[63:60] != 4'd0)
                            ovf_w = 1'b1;
                        else
                            acc_w = {acc_reg[59:0], hex[3:0]};
                    end
                    else
                        phase_w = PH_DONE;
                end
                default:
                begin
                    phase_w = phase_reg;
                end
            endcase
        end
    end

    assign kind_eff  = (seglen_w == 2'd1) ? kind_from_one(lead_w) : kind_w;
    assign kind_ok   = kind_eff >= K_GE && kind_eff <= K_EQ;
    assign phase_bad = phase_w == PH_PREFIX || phase_w == PH_HEXWAIT || phase_w == PH_BAD;

    assign close_event.comma      = is_comma;
    assign close_event.last       = item.last;
    assign close_event.sep_or_len = sep_reg || (seglen_w != 2'd0);
    assign close_event.seg.kind   = kind_eff;
    assign close_event.seg.bad    = seglen_w == 2'd0 || phase_bad || ovf_w || !kind_ok;
    assign close_event.seg.number = acc_w;
    assign close_event.value      = item.value;

    always_comb
    begin
        phase_next  = phase_w;
        seglen_next = seglen_w;
        lead_next   = lead_w;
        kind_next   = kind_w;
        acc_next    = acc_w;
        ovf_next    = ovf_w;
        sep_next    = sep_reg;
        if (item.last || is_comma)
        begin
            phase_next  = PH_PREFIX;
            seglen_next = 2'd0;
            lead_next   = 8'd0;
            kind_next   = K_NONE;
            acc_next    = 64'd0;
            ovf_next    = 1'b0;
            sep_next    = !item.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_PREFIX;
            seglen_reg <= 2'd0;
            lead_reg   <= 8'd0;
            kind_reg   <= K_NONE;
            acc_reg    <= 64'd0;
            ovf_reg    <= 1'b0;
            sep_reg    <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            seglen_reg <= seglen_next;
            lead_reg   <= lead_next;
            kind_reg   <= kind_next;
            acc_reg    <= acc_next;
            ovf_reg    <= ovf_next;
            sep_reg    <= sep_next;
        end
    end

endmodule

// File: rtl/cef_judge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cef_judge
// Compares the value against each closed segment and keeps the running
// verdict of the expression.
// ----------------------------------------------------------------------------
module cef_judge
    import cef_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  event_t     close_event,
    input  logic       advance,
    output logic [1:0] verdict
);

    logic [1:0] verdict_so_far_reg, verdict_so_far_next;
    logic [1:0] close_verdict;
    logic [1:0] after_comma;
    logic       holds;

    always_comb
    begin
        case (close_event.seg.kind)
            K_GE:    holds = close_event.value >= close_event.seg.number;
            K_LE:    holds = close_event.value <= close_event.seg.number;
            K_GT:    holds = close_event.value >  close_event.seg.number;
            K_LT:    holds = close_event.value <  close_event.seg.number;
            K_NE:    holds = close_event.value != close_event.seg.number;
            K_EQ:    holds = close_event.value == close_event.seg.number;
            default: holds = 1'b0;
        endcase
    end

    assign close_verdict = close_event.seg.bad ? VERDICT_SYNTAX :
                           (holds ? VERDICT_PASS : VERDICT_FAIL);

    // Only the first failing segment counts.
    assign after_comma = (close_event.comma && verdict_so_far_reg == VERDICT_PASS) ?
                         close_verdict : verdict_so_far_reg;

    // A comma that ends the expression leaves an empty segment behind it.
    always_comb
    begin
        if (close_event.comma)
            verdict = (after_comma == VERDICT_PASS) ? VERDICT_SYNTAX : after_comma;
        else if (verdict_so_far_reg == VERDICT_PASS && close_event.sep_or_len)
            verdict = close_verdict;
        else
            verdict = verdict_so_far_reg;
    end

    assign verdict_so_far_next = close_event.last ? VERDICT_PASS : after_comma;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            verdict_so_far_reg <= VERDICT_PASS;
        else if (advance)
            verdict_so_far_reg <= verdict_so_far_next;
    end

endmodule

// File: rtl/compare_expression_filter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compare_expression_filter_unit
// Checks a 64-bit value against a comma-separated comparison expression
// streamed one character per item; gives one verdict per expression.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload                          Accepted when
//  expr      sink       symbol[7:0], value[63:0], last   valid && ready
//  result    source     verdict[1:0]                     valid && ready
//
// One character item is taken every clock cycle unless a close item waits on a full
// compare stage; the accumulator update (times ten plus digit) is the parser stage's longest path.
// A verdict reaches the output register through the input register, the parser
// stage and the compare stage, after its last item is accepted.
// Reset clears the parser and the running verdict; no clearing pass.
// A stalled result holds the output register; upstream items keep entering until
// a comma or final item waits in the input register behind a held final close.
// ----------------------------------------------------------------------------
`include "compare_expression_filter_unit_macros.svh"

module compare_expression_filter_unit
    import cef_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    cef_expr_if.sink        expr,
    cef_result_if.source    result
);

    item_t   a_reg;
    logic    a_vld_reg;
    event_t  b_reg;
    logic    b_vld_reg;
    result_t o_reg;
    logic    o_vld_reg;

    event_t     close_event;
    logic [1:0] judged;
    logic       a_close;
    logic       o_room;
    logic       b_adv;
    logic       b_room;
    logic       a_adv;
    logic       a_room;

    // Only commas and final characters reach the compare stage.
    assign a_close = a_reg.last || a_reg.symbol == CH_COMMA;
    assign o_room  = !o_vld_reg || result.ready;
    assign b_adv   = b_vld_reg && (!b_reg.last || o_room);
    assign b_room  = !b_vld_reg || b_adv;
    assign a_adv   = a_vld_reg && (!a_close || b_room);
    assign a_room  = !a_vld_reg || a_adv;

    assign expr.ready     = a_room;
    assign result.valid   = o_vld_reg;
    assign result.payload = o_reg;

    cef_parser u_parser
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (a_reg),
        .advance     (a_adv),
        .close_event (close_event)
    );

    cef_judge u_judge
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .close_event (b_reg),
        .advance     (b_adv),
        .verdict     (judged)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            o_vld_reg <= 1'b0;
        end
        else
        begin
            if (a_room)
                a_vld_reg <= expr.valid;
            if (a_adv && a_close)
                b_vld_reg <= 1'b1;
            else if (b_adv)
                b_vld_reg <= 1'b0;
            if (b_adv && b_reg.last)
                o_vld_reg <= 1'b1;
            else if (result.ready)
                o_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_room && expr.valid)
            a_reg <= expr.payload;
        if (a_adv && a_close)
            b_reg <= close_event;
        if (b_adv && b_reg.last)
            o_reg.verdict <= judged;
    end

    `CEF_ASSERT_SAME(a_stall_only_when_full, !expr.ready, a_vld_reg, "input stalled while empty")
    `CEF_ASSERT_NEXT(a_final_reaches_output, b_adv && b_reg.last, o_vld_reg, "final close lost")
    `CEF_ASSERT_SAME(a_verdict_legal, o_vld_reg, o_reg.verdict <= VERDICT_SYNTAX, "bad verdict")

endmodule
